// ----- rtl/core/frame_playback_sequencer_macros.svh -----
// assertion macros for the frame playback sequencer checker
`ifndef FRAME_PLAYBACK_SEQUENCER_MACROS_SVH
`define FRAME_PLAYBACK_SEQUENCER_MACROS_SVH

// plain property check, reset disables it
`define FPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("fps port check failed");

// same-cycle implication
`define FPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error("fps port check failed");

`endif

// ----- rtl/core/fps_pkg.sv -----
// shared types, codes and constants of the frame playback sequencer
`default_nettype none
package fps_pkg;

  localparam int MAX_FRAMES_DEF = 256;

  // command codes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_STEPBK  = 2'd2;
  localparam logic [1:0] OP_SETDIR  = 2'd3;

  // playback modes
  localparam logic [1:0] MODE_LOOP   = 2'd0;
  localparam logic [1:0] MODE_ONCE   = 2'd1;
  localparam logic [1:0] MODE_BOUNCE = 2'd2;
  localparam logic [1:0] MODE_LOOPN  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_CNT = 2'd0;
  localparam logic [1:0] CFG_PB_TYPE   = 2'd1;
  localparam logic [1:0] CFG_MAX_LOOPS = 2'd2;

  localparam logic [15:0] LOOP_SAT = 16'hFFFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] seek_frame;
    logic       start_at_last;
    logic       forward;
  } fps_in_t;

  typedef struct packed {
    logic [7:0]  frame;
    logic        frame_valid;
    logic [7:0]  prev_frame;
    logic        prev_valid;
    logic [7:0]  next_frame;
    logic        next_valid;
    logic [15:0] loops_done;
    logic        dir_forward;
    logic        done_res;
  } fps_out_t;

  typedef struct packed {
    logic [7:0]  cur_frame;
    logic        cur_valid;
    logic [7:0]  prev_frame;
    logic        prev_valid;
    logic [7:0]  anchor_idx;
    logic [15:0] loop_cnt;
    logic        dir;
    logic        running;
  } fps_state_t;

  typedef struct packed {
    logic [7:0]  last_idx;
    logic [1:0]  pb_type;
    logic [15:0] max_loops;
  } fps_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/frame_playback_sequencer.sv -----
// top level of the animation frame playback sequencer
//
// usage:
//   in_*  : command channel (valid/stall). one transaction is one command:
//           start, advance, step back or set direction.
//   out_* : result channel (valid/stall). exactly one result transaction per
//           command, in order: current, previous and look-ahead frame with
//           valid flags, loop count, direction and done.
//   cfg_* : plain write port for the frame count, playback_type and
//           max_loops; write only while no command is in flight.
//   order: an accepted command is held in the command register, then its
//           result is registered in the result register that drives
//           out_valid; a stalled result can hold it in the command register.
//   throughput: one command per cycle unless out_stall holds the result;
//           state update plus look-ahead is combinational between registers.
//   reset: state goes idle (blank frames, forward, count zero), config goes
//           to 2 frames, loop mode, max_loops 1, both pipeline stages empty.
//   stall: a stalled result holds; the command register still takes one
//           more command, then in_stall rises until the result is taken.
`default_nettype none
module frame_playback_sequencer #(
  parameter int MAX_FRAMES = fps_pkg::MAX_FRAMES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // command channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fps_pkg::fps_in_t  in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fps_pkg::fps_out_t      out_data,
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata
);

  // frame count ceiling: the parameter, and never beyond 8-bit indexes
  localparam int          LIM_INT   = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
  localparam logic [8:0]  FRAME_LIM = 9'(LIM_INT);

  // configuration registers
  logic [8:0]  frame_cnt_r;
  logic [1:0]  pb_type_r;
  logic [15:0] max_loops_r;

  // pipeline registers
  fps_pkg::fps_in_t    cmd_r;
  logic                cmd_vld_r;
  fps_pkg::fps_out_t   out_r;
  logic                out_vld_r;
  fps_pkg::fps_state_t st_r;

  fps_pkg::fps_cfg_t   cfg;
  fps_pkg::fps_state_t st_nxt;
  fps_pkg::fps_state_t look_st;
  fps_pkg::fps_out_t   out_nxt;
  logic [8:0]          nf_clamped;
  logic                res_ready;
  logic                in_acc;

  // clamp the frame count, last index = count - 1
  always_comb begin
    nf_clamped = frame_cnt_r;
    if (nf_clamped > FRAME_LIM) nf_clamped = FRAME_LIM;
    if (nf_clamped < 9'd2)      nf_clamped = 9'd2;
  end

  assign cfg.last_idx  = 8'(nf_clamped - 9'd1);
  assign cfg.pb_type   = pb_type_r;
  assign cfg.max_loops = max_loops_r;

  // result stage can load when empty or being drained
  assign res_ready = !out_vld_r || !out_stall;
  assign in_stall  = cmd_vld_r && !res_ready;
  assign in_acc    = in_valid && !in_stall;

  // command applied to the stored state
  fps_step u_step (
    .cmd_i (cmd_r),
    .st_i  (st_r),
    .cfg_i (cfg),
    .st_o  (st_nxt)
  );

  // look-ahead: what an advance would give from the new state
  fps_advance u_look (
    .st_i  (st_nxt),
    .cfg_i (cfg),
    .st_o  (look_st)
  );

  // result formatting; blank indexes read as zero
  always_comb begin
    logic cv;
    logic pv;
    logic nv;
    cv = st_nxt.running && st_nxt.cur_valid;
    pv = st_nxt.running && st_nxt.prev_valid;
    nv = st_nxt.running && look_st.running && look_st.cur_valid;
    out_nxt.frame       = cv ? st_nxt.cur_frame : 8'd0;
    out_nxt.frame_valid = cv;
    out_nxt.prev_frame  = pv ? st_nxt.prev_frame : 8'd0;
    out_nxt.prev_valid  = pv;
    out_nxt.next_frame  = nv ? look_st.cur_frame : 8'd0;
    out_nxt.next_valid  = nv;
    out_nxt.loops_done  = st_nxt.loop_cnt;
    out_nxt.dir_forward = st_nxt.dir;
    out_nxt.done_res    = !st_nxt.running;
  end

  // configuration writes; index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= 9'd2;
      pb_type_r   <= fps_pkg::MODE_LOOP;
      max_loops_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        fps_pkg::CFG_FRAME_CNT: frame_cnt_r <= cfg_wdata[8:0];
        fps_pkg::CFG_PB_TYPE:   pb_type_r   <= cfg_wdata[1:0];
        fps_pkg::CFG_MAX_LOOPS: max_loops_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state of the two stages and the playback state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r       <= 1'b0;
      out_vld_r       <= 1'b0;
      st_r.cur_frame  <= 8'd0;
      st_r.cur_valid  <= 1'b0;
      st_r.prev_frame <= 8'd0;
      st_r.prev_valid <= 1'b0;
      st_r.anchor_idx <= 8'd0;
      st_r.loop_cnt   <= 16'd0;
      st_r.dir        <= 1'b1;
      st_r.running    <= 1'b0;
    end else begin
      cmd_vld_r <= (cmd_vld_r && !res_ready) || in_acc;
      if (res_ready) out_vld_r <= cmd_vld_r;
      if (res_ready && cmd_vld_r) st_r <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) cmd_r <= in_data;
    if (res_ready && cmd_vld_r) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- rtl/core/fps_advance.sv -----
// one-frame advance of the playback state, edge and mode handling
`default_nettype none
module fps_advance (
  input  wire fps_pkg::fps_state_t st_i,
  input  wire fps_pkg::fps_cfg_t   cfg_i,
  output fps_pkg::fps_state_t      st_o
);

  always_comb begin
    logic        edge_fr;
    logic        ok;
    logic [8:0]  nx;
    logic        under;
    logic [15:0] cnt;
    logic        dir;
    logic [8:0]  plus1;
    logic [8:0]  minus1;

    st_o   = st_i;
    ok     = 1'b1;
    under  = 1'b0;
    nx     = 9'd0;
    cnt    = st_i.loop_cnt;
    dir    = st_i.dir;
    plus1  = {1'b0, st_i.cur_frame} + 9'd1;
    minus1 = {1'b0, st_i.cur_frame} - 9'd1;
    edge_fr = !((st_i.cur_frame != 8'd0) && (st_i.cur_frame < cfg_i.last_idx));

    if (!edge_fr) begin
      nx = dir ? plus1 : minus1;
    end else begin
      case (cfg_i.pb_type)
        fps_pkg::MODE_LOOP, fps_pkg::MODE_LOOPN: begin
          if (st_i.cur_frame == st_i.anchor_idx && cnt != fps_pkg::LOOP_SAT)
            cnt = cnt + 16'd1;
          if (cfg_i.pb_type == fps_pkg::MODE_LOOPN && cnt >= cfg_i.max_loops) begin
            ok = 1'b0;
          end else if (dir) begin
            nx = (st_i.cur_frame != 8'd0) ? 9'd0 : 9'd1;
          end else if (st_i.cur_frame == 8'd0) begin
            nx = {1'b0, cfg_i.last_idx};
          end else begin
            nx = minus1;
          end
        end
        fps_pkg::MODE_ONCE: begin
          if (st_i.cur_frame != st_i.anchor_idx) begin
            ok = 1'b0;
          end else if (dir) begin
            nx = (st_i.cur_frame == 8'd0) ? 9'd1 : 9'd0;
          end else if (st_i.cur_frame != 8'd0) begin
            nx = minus1;
          end else begin
            nx = {1'b0, cfg_i.last_idx};
          end
        end
        default: begin
          // bounce: every edge counts; the direction reverses unless the count has just reached one
          if (cnt != fps_pkg::LOOP_SAT) cnt = cnt + 16'd1;
          if (cnt != 16'd1) dir = ~dir;
          if (dir) begin
            nx = plus1;
          end else begin
            nx    = minus1;
            under = (st_i.cur_frame == 8'd0);
          end
        end
      endcase
    end

    if (ok && (under || nx > {1'b0, cfg_i.last_idx})) ok = 1'b0;

    if (!st_i.running) begin
      st_o = st_i;
    end else if (!st_i.cur_valid) begin
      st_o.running = 1'b0;
    end else begin
      st_o.loop_cnt   = cnt;
      st_o.dir        = dir;
      st_o.prev_frame = st_i.cur_frame;
      st_o.prev_valid = 1'b1;
      if (ok) begin
        st_o.cur_frame = nx[7:0];
        st_o.cur_valid = 1'b1;
      end else begin
        st_o.cur_frame = 8'd0;
        st_o.cur_valid = 1'b0;
        st_o.running   = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/fps_step.sv -----
// applies one command to the playback state
`default_nettype none
module fps_step (
  input  wire fps_pkg::fps_in_t    cmd_i,
  input  wire fps_pkg::fps_state_t st_i,
  input  wire fps_pkg::fps_cfg_t   cfg_i,
  output fps_pkg::fps_state_t      st_o
);

  fps_pkg::fps_state_t adv_st;

  fps_advance u_adv (
    .st_i  (st_i),
    .cfg_i (cfg_i),
    .st_o  (adv_st)
  );

  always_comb begin
    st_o = st_i;
    case (cmd_i.opcode)
      fps_pkg::OP_START: begin
        st_o.running    = 1'b1;
        st_o.anchor_idx = cmd_i.start_at_last ? cfg_i.last_idx : cmd_i.seek_frame;
        st_o.cur_frame  = cmd_i.start_at_last ? cfg_i.last_idx : cmd_i.seek_frame;
        st_o.cur_valid  = 1'b1;
        st_o.loop_cnt   = 16'd0;
      end
      fps_pkg::OP_ADVANCE: begin
        st_o = adv_st;
      end
      fps_pkg::OP_STEPBK: begin
        st_o.cur_frame  = st_i.prev_frame;
        st_o.cur_valid  = st_i.prev_valid;
        st_o.prev_frame = st_i.cur_frame;
        st_o.prev_valid = st_i.cur_valid;
      end
      default: begin
        st_o.dir = cmd_i.forward;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/fps_checker.sv -----
// port-level checker of the frame playback sequencer and its bind
`default_nettype none
`include "frame_playback_sequencer_macros.svh"
module fps_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire fps_pkg::fps_out_t out_data
);

  // a stalled result transaction stays and holds its payload
  `FPS_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))

  // a shown frame means playback is running
  `FPS_ASSERT_IMPL(a_frame_running, clk, rst_n, out_valid && (out_data.frame_valid || out_data.prev_valid), !out_data.done_res)

  // a look-ahead frame exists only from a shown current frame
  `FPS_ASSERT_IMPL(a_next_needs_cur, clk, rst_n, out_valid && out_data.next_valid, out_data.frame_valid)

  // blank frames read as index zero
  `FPS_ASSERT_IMPL(a_blank_zero, clk, rst_n, out_valid && !out_data.frame_valid, out_data.frame == 8'd0)

endmodule

bind frame_playback_sequencer fps_checker u_fps_checker (.*);
`default_nettype wire
